FILE: src/radix2_fft_engine_assert.svh
// Assertion macros used by the checker file of this project.
`ifndef RADIX2_FFT_ENGINE_ASSERT_SVH
`define RADIX2_FFT_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define R2FFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define R2FFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/r2fft_pkg.sv
`timescale 1ns / 1ps
package r2fft_pkg;

  // Stored values and bins are 27-bit signed numbers.
  localparam int VALUE_BITS = 27;

  localparam int DEF_POINTS       = 1024;
  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int DEF_TWIDDLE_BITS = 16;

  // Request codes.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Result codes.
  localparam logic RES_BIN  = 1'b0;
  localparam logic RES_DONE = 1'b1;

  localparam longint unsigned Q60_ONE     = 64'h1000000000000000;
  localparam longint unsigned HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam longint unsigned TWO_PI_Q60  = 64'h6487ED5110B4611A;

  // Truncated Q60 product of two values below 2^62.
  function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
    longint unsigned ah, al, bh, bl, hi, mid, lo;
    ah  = a >> 32;
    al  = a & 64'hFFFFFFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFFFFFF;
    hi  = ah * bh;
    mid = ah * bl + al * bh;
    lo  = al * bl;
    return (hi << 4) + ((mid + (lo >> 32)) >> 28);
  endfunction

  // Unsigned quotient by restoring long division; only used while the twiddle
  // table is built.
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Converts a Q60 value in [-1, 1] to a rounded, saturated twiddle.
  function automatic longint to_tw(longint v, int unsigned tbits);
    int unsigned sh;
    longint unsigned u;
    longint w, mx;
    sh = 61 - tbits;
    u  = longint'(v + longint'(Q60_ONE)) + (64'd1 << (sh - 1));
    w  = longint'(u >> sh) - (longint'(1) << (tbits - 1));
    mx = (longint'(1) << (tbits - 1)) - 1;
    return (w > mx) ? mx : w;
  endfunction

  // Twiddle pair for angle 2*pi*k/2^lg: cosine in [63:32], sine in [31:0].
  // Evaluated at elaboration only.
  function automatic logic [63:0] twiddle_pair(int unsigned k, int unsigned lg,
                                               int unsigned tbits);
    longint unsigned x, term, kk;
    longint cs, sn, c, s;
    logic signed [63:0] tc, ts;
    logic quad;
    kk   = longint'(k);
    x    = (TWO_PI_Q60 >> lg) * kk
         + (((TWO_PI_Q60 & ((64'd1 << lg) - 1)) * kk) >> lg);
    quad = (x >= HALF_PI_Q60);
    if (quad) begin
      x = x - HALF_PI_Q60;
    end
    term = Q60_ONE;
    cs   = 0;
    sn   = 0;
    for (int unsigned n = 0; n < 28; n++) begin
      case (n % 4)
        0: cs = cs + longint'(term);
        1: sn = sn + longint'(term);
        2: cs = cs - longint'(term);
        default: sn = sn - longint'(term);
      endcase
      term = udiv64(mul_q60(term, x), longint'(n + 1));
    end
    if (quad) begin
      c = -sn;
      s = cs;
    end else begin
      c = cs;
      s = sn;
    end
    tc = to_tw(c, tbits);
    ts = to_tw(s, tbits);
    return {tc[31:0], ts[31:0]};
  endfunction

  // Stage enables and inverse-mode bit of the butterfly datapath.
  typedef struct packed {
    logic mul_en;
    logic sum_en;
    logic inverse;
  } bfly_ctrl_t;

endpackage

FILE: src/r2fft_ram.sv
`timescale 1ns / 1ps
module r2fft_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/r2fft_bfly.sv
`timescale 1ns / 1ps
module r2fft_bfly #(
  parameter int TWIDDLE_BITS = r2fft_pkg::DEF_TWIDDLE_BITS
) (
  input  logic                                  clk,
  input  r2fft_pkg::bfly_ctrl_t                 ctrl,
  input  logic signed [r2fft_pkg::VALUE_BITS-1:0] a_re,
  input  logic signed [r2fft_pkg::VALUE_BITS-1:0] a_im,
  input  logic signed [r2fft_pkg::VALUE_BITS-1:0] b_re,
  input  logic signed [r2fft_pkg::VALUE_BITS-1:0] b_im,
  input  logic signed [TWIDDLE_BITS-1:0]        w_cos,
  input  logic signed [TWIDDLE_BITS-1:0]        w_sin,
  output logic signed [r2fft_pkg::VALUE_BITS-1:0] u_re,
  output logic signed [r2fft_pkg::VALUE_BITS-1:0] u_im,
  output logic signed [r2fft_pkg::VALUE_BITS-1:0] v_re,
  output logic signed [r2fft_pkg::VALUE_BITS-1:0] v_im
);

  localparam int VB = r2fft_pkg::VALUE_BITS;
  localparam int PW = VB + TWIDDLE_BITS + 1;
  localparam int SW = PW + 3;
  localparam logic signed [SW-1:0] RND  = SW'(1) << (TWIDDLE_BITS - 2);
  localparam logic signed [SW-1:0] MAXV = (SW'(1) << (VB - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -(SW'(1) << (VB - 1));

  logic signed [TWIDDLE_BITS:0] wr, ws, wi;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [SW-1:0] xr, xi, tr, ti, ur, ui, vr, vi;
  logic signed [SW-1:0] ae_re, ae_im;

  function automatic logic signed [VB-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (v > MAXV) begin
      r = MAXV;
    end else if (v < MINV) begin
      r = MINV;
    end
    return r[VB-1:0];
  endfunction

  // The inverse transform conjugates the twiddle.
  assign wr = {w_cos[TWIDDLE_BITS-1], w_cos};
  assign ws = {w_sin[TWIDDLE_BITS-1], w_sin};
  assign wi = ctrl.inverse ? ws : -ws;

  // First stage: the four partial products of b times w.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p_rr <= PW'(b_re * wr);
      p_ii <= PW'(b_im * wi);
      p_ri <= PW'(b_re * wi);
      p_ir <= PW'(b_im * wr);
    end
  end

  // Second stage: combine and round the products, add and subtract, halve in inverse mode.
  always_comb begin
    xr    = SW'(p_rr) - SW'(p_ii);
    xi    = SW'(p_ri) + SW'(p_ir);
    tr    = (xr + RND) >>> (TWIDDLE_BITS - 1);
    ti    = (xi + RND) >>> (TWIDDLE_BITS - 1);
    ae_re = SW'(a_re);
    ae_im = SW'(a_im);
    ur    = ae_re + tr;
    ui    = ae_im + ti;
    vr    = ae_re - tr;
    vi    = ae_im - ti;
    if (ctrl.inverse) begin
      ur = (ur + SW'(1)) >>> 1;
      ui = (ui + SW'(1)) >>> 1;
      vr = (vr + SW'(1)) >>> 1;
      vi = (vi + SW'(1)) >>> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      u_re <= sat(ur);
      u_im <= sat(ui);
      v_re <= sat(vr);
      v_im <= sat(vi);
    end
  end

endmodule

FILE: src/radix2_fft_engine.sv
`timescale 1ns / 1ps
// Radix-2 decimation-in-time FFT over POINTS complex samples held in one
// single-port-read RAM. A load transaction writes one sample. A read
// transaction passes through the READ state, which keeps the input
// closed, and then offers its bin from the output register. A run
// transaction first reorders the RAM by bit reversal, then performs
// POINTS/2 * log2(POINTS) butterflies, each through two RAM reads, a
// multiply stage, an add stage and two RAM writes, since the RAM gives
// one read a cycle. At the end of a run a done transaction is returned.
// inverse_mode (bit 0 of the configuration register) selects the
// inverse transform with 1/N scaling; write it only while no transaction
// is in progress.
module radix2_fft_engine #(
  parameter int POINTS       = r2fft_pkg::DEF_POINTS,
  parameter int SAMPLE_BITS  = r2fft_pkg::DEF_SAMPLE_BITS,
  parameter int TWIDDLE_BITS = r2fft_pkg::DEF_TWIDDLE_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              req_type,
  input  logic [9:0]                              point_index,
  input  logic signed [SAMPLE_BITS-1:0]           sample_re,
  input  logic signed [SAMPLE_BITS-1:0]           sample_im,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    result_kind,
  output logic [9:0]                              bin_number,
  output logic signed [r2fft_pkg::VALUE_BITS-1:0] bin_re,
  output logic signed [r2fft_pkg::VALUE_BITS-1:0] bin_im,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [1:0]                              paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  localparam int VB       = r2fft_pkg::VALUE_BITS;
  localparam int LG       = $clog2(POINTS);
  localparam int AW       = LG;
  localparam int BCW      = (LG > 1) ? LG - 1 : 1;
  localparam int STW      = (LG > 1) ? $clog2(LG) : 1;
  localparam int TW_DEPTH = POINTS / 2;
  localparam int TW_AW    = (LG > 1) ? LG - 1 : 1;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_READ = 9'b000000010,
    ST_RDA  = 9'b000000100,
    ST_RDB  = 9'b000001000,
    ST_MUL  = 9'b000010000,
    ST_SUM  = 9'b000100000,
    ST_WRA  = 9'b001000000,
    ST_WRB  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic inverse_mode;
  logic reorder;
  logic [AW-1:0] ri;
  logic [STW-1:0] stg;
  logic [BCW-1:0] bc;
  logic [AW-1:0] bc_ext, ia, ib, rev, kmask, tidx_full;
  logic [STW-1:0] tshift;
  logic [TW_AW-1:0] tidx;
  logic [AW-1:0] pa, pb;
  logic [AW-1:0] idx_addr;
  logic idx_ok, rd_ok;
  logic [9:0] rd_idx;
  logic in_acc;
  logic last_pair;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2*VB-1:0] ram_wdata, ram_rdata;

  logic signed [VB-1:0] a_re, a_im, b_re, b_im;
  logic signed [VB-1:0] u_re, u_im, v_re, v_im;
  logic signed [TWIDDLE_BITS-1:0] tw_cos_rom [TW_DEPTH];
  logic signed [TWIDDLE_BITS-1:0] tw_sin_rom [TW_DEPTH];
  logic signed [TWIDDLE_BITS-1:0] w_cos, w_sin;
  r2fft_pkg::bfly_ctrl_t bctrl;

  // Configuration register; every write lands on inverse_mode.
  assign pready = 1'b1;
  assign prdata = {31'b0, inverse_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      inverse_mode <= pwdata[0];
    end
  end

  // Twiddle table, evaluated at elaboration.
  for (genvar g = 0; g < TW_DEPTH; g++) begin : g_tw
    localparam logic [63:0] TWP = r2fft_pkg::twiddle_pair(g, LG, TWIDDLE_BITS);
    assign tw_cos_rom[g] = TWP[32 +: TWIDDLE_BITS];
    assign tw_sin_rom[g] = TWP[0 +: TWIDDLE_BITS];
  end

  // Butterfly addresses: a zero bit inserted at position stg of the counter.
  always_comb begin
    bc_ext = AW'(bc);
    for (int j = 0; j < AW; j++) begin
      if (j < int'(stg)) begin
        ia[j] = bc_ext[j];
      end else if (j == int'(stg)) begin
        ia[j] = 1'b0;
      end else begin
        ia[j] = bc_ext[(j > 0) ? j - 1 : 0];
      end
      rev[j] = ri[AW-1-j];
    end
    ib        = ia | (AW'(1) << stg);
    kmask     = (AW'(1) << stg) - AW'(1);
    tshift    = STW'(LG - 1) - stg;
    tidx_full = (bc_ext & kmask) << tshift;
    tidx      = tidx_full[TW_AW-1:0];
    pa        = reorder ? ri : ia;
    pb        = reorder ? rev : ib;
  end

  assign last_pair = (bc == BCW'(POINTS / 2 - 1)) && (stg == STW'(LG - 1));

  // Input handshake and request decode.
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign idx_addr = AW'(point_index);
  assign idx_ok   = 32'(point_index) < 32'(POINTS);

  // RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pa;
    ram_wdata = {u_re, u_im};
    ram_raddr = pa;
    case (state)
      ST_IDLE: begin
        ram_raddr = idx_addr;
        ram_waddr = idx_addr;
        ram_wdata = {VB'(sample_re), VB'(sample_im)};
        ram_we    = in_acc && (req_type == r2fft_pkg::REQ_LOAD) && idx_ok;
      end
      ST_RDB: begin
        ram_raddr = pb;
      end
      ST_WRA: begin
        ram_we    = 1'b1;
        ram_waddr = pa;
        ram_wdata = reorder ? {b_re, b_im} : {u_re, u_im};
      end
      ST_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = pb;
        ram_wdata = reorder ? {a_re, a_im} : {v_re, v_im};
      end
      default: begin
        ram_raddr = pa;
      end
    endcase
  end

  r2fft_ram #(
    .WIDTH(2 * VB),
    .DEPTH(POINTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign bctrl.mul_en  = (state == ST_MUL);
  assign bctrl.sum_en  = (state == ST_SUM);
  assign bctrl.inverse = inverse_mode;

  r2fft_bfly #(
    .TWIDDLE_BITS(TWIDDLE_BITS)
  ) u_bfly (
    .clk  (clk),
    .ctrl (bctrl),
    .a_re (a_re),
    .a_im (a_im),
    .b_re (ram_rdata[2*VB-1:VB]),
    .b_im (ram_rdata[VB-1:0]),
    .w_cos(w_cos),
    .w_sin(w_sin),
    .u_re (u_re),
    .u_im (u_im),
    .v_re (v_re),
    .v_im (v_im)
  );

  // Operand capture and twiddle read.
  always_ff @(posedge clk) begin
    if (state == ST_RDA) begin
      w_cos <= tw_cos_rom[tidx];
      w_sin <= tw_sin_rom[tidx];
    end
    if (state == ST_RDB) begin
      a_re <= ram_rdata[2*VB-1:VB];
      a_im <= ram_rdata[VB-1:0];
    end
    if (state == ST_MUL) begin
      b_re <= ram_rdata[2*VB-1:VB];
      b_im <= ram_rdata[VB-1:0];
    end
    if (in_acc) begin
      rd_idx <= point_index;
      rd_ok  <= idx_ok;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (req_type == r2fft_pkg::REQ_READ)) begin
          state_next = ST_READ;
        end else if (in_acc && (req_type == r2fft_pkg::REQ_RUN)) begin
          state_next = ST_RDA;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_RDA: begin
        if (reorder && (rev <= ri)) begin
          state_next = (ri == AW'(POINTS - 1)) ? ST_RDA : ST_RDA;
        end else begin
          state_next = ST_RDB;
        end
      end
      ST_RDB: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_WRA;
      end
      ST_WRA: begin
        state_next = ST_WRB;
      end
      ST_WRB: begin
        state_next = (!reorder && last_pair) ? ST_DONE : ST_RDA;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer: pair counters advance when a pair is skipped or written back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      reorder <= 1'b0;
      ri      <= '0;
      stg     <= '0;
      bc      <= '0;
    end else begin
      state <= state_next;
      if (in_acc && (req_type == r2fft_pkg::REQ_RUN)) begin
        reorder <= 1'b1;
        ri      <= '0;
        stg     <= '0;
        bc      <= '0;
      end else if ((state == ST_WRB) || ((state == ST_RDA) && reorder && (rev <= ri))) begin
        if (reorder) begin
          if (ri == AW'(POINTS - 1)) begin
            reorder <= 1'b0;
          end else begin
            ri <= ri + AW'(1);
          end
        end else if (bc == BCW'(POINTS / 2 - 1)) begin
          bc <= '0;
          if (!last_pair) begin
            stg <= stg + STW'(1);
          end
        end else begin
          bc <= bc + BCW'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_READ) begin
      out_valid <= 1'b1;
    end else if ((state == ST_DONE) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      result_kind <= r2fft_pkg::RES_BIN;
      bin_number  <= rd_idx;
      bin_re      <= rd_ok ? ram_rdata[2*VB-1:VB] : '0;
      bin_im      <= rd_ok ? ram_rdata[VB-1:0] : '0;
    end else if ((state == ST_DONE) && (!out_valid || out_ready)) begin
      result_kind <= r2fft_pkg::RES_DONE;
      bin_number  <= '0;
      bin_re      <= '0;
      bin_im      <= '0;
    end
  end

endmodule

FILE: src/r2fft_checker.sv
`timescale 1ns / 1ps
`include "radix2_fft_engine_assert.svh"
module r2fft_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic       pready
);

  // A new transaction is taken only when the result slot is free or draining.
  `R2FFT_ASSERT_NOW(a_slot_free, in_ready, !out_valid || out_ready, "input taken with result stuck")

  // A read keeps the block busy while the bin is fetched.
  `R2FFT_ASSERT_NEXT(a_read_busy, in_valid && in_ready && (req_type == r2fft_pkg::REQ_READ), !in_ready, "input ready during read")

  // A run keeps the block busy.
  `R2FFT_ASSERT_NEXT(a_run_busy, in_valid && in_ready && (req_type == r2fft_pkg::REQ_RUN), !in_ready, "input ready during run")

  // A result waiting on the consumer stays offered.
  `R2FFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

  // The configuration port never inserts wait states.
  `R2FFT_ASSERT_NOW(a_pready, 1'b1, pready, "configuration port stalled")

endmodule

bind radix2_fft_engine r2fft_checker u_r2fft_checker (.*);
